// ----- hw/rtl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    // Field widths of the pixel items.
    localparam int INPUT_W  = 13;
    localparam int CHAN_W   = 8;
    localparam int SECTOR_W = 3;
    localparam int REM_W    = 10;

    // Default number of fraction bits of saturation and brightness.
    localparam int FRACTION_BITS_DEF = 12;

    // Hue is clamped to 359 degrees in 1/16 degree units; one sector spans 60 degrees.
    localparam logic [INPUT_W-1:0] HUE_MAX = INPUT_W'(5744);
    localparam int SECTOR_UNITS = 960;

    // The sector width splits as 15 times 2^6; the power of two folds into the shift.
    localparam int SECTOR_SHIFT = 6;

    // Channel scale 255 is 2^8 - 1, done as a shift and a subtract.
    localparam int CHAN_SHIFT = 8;

    // Division by 15 of a quotient below 3840: multiply by 2185 and drop 15 bits.
    localparam int QUOT_W = 12;
    localparam logic [QUOT_W-1:0] RECIP15 = QUOT_W'(2185);
    localparam int RECIP_SHIFT = 15;

    // Register stages from the input handshake to the output register.
    localparam int PIPE_DEPTH = 6;

    // Hue sectors of 60 degrees each.
    typedef enum logic [SECTOR_W-1:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } sector_t;

    typedef struct packed {
        logic [INPUT_W-1:0] hue;
        logic [INPUT_W-1:0] saturation;
        logic [INPUT_W-1:0] brightness;
    } hsv_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_pixel_t;

    // Load enables of the three stages inside a channel lane.
    typedef struct packed {
        logic mul;
        logic scale;
        logic recip;
    } lane_en_t;

endpackage

// ----- hw/rtl/hsv2rgb_lane.sv -----
// One color channel: brightness times the channel's component numerator,
// scaled by 255 and divided by 960 * ONE * ONE with truncation.
module hsv2rgb_lane #(
    parameter int FRACTION_BITS = hsv2rgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  hsv2rgb_pkg::lane_en_t         en,
    input  logic [((FRACTION_BITS + 1 > hsv2rgb_pkg::INPUT_W) ?
                   FRACTION_BITS + 1 : hsv2rgb_pkg::INPUT_W) - 1:0] bright,
    input  logic [FRACTION_BITS + hsv2rgb_pkg::REM_W - 1:0] comp,
    output logic [hsv2rgb_pkg::CHAN_W-1:0] chan
);

    localparam int VAL_W = (FRACTION_BITS + 1 > hsv2rgb_pkg::INPUT_W) ?
                           FRACTION_BITS + 1 : hsv2rgb_pkg::INPUT_W;
    localparam int ARG_W = FRACTION_BITS + hsv2rgb_pkg::REM_W;
    localparam int PROD_W = VAL_W + ARG_W;
    localparam int SCALED_W = PROD_W + hsv2rgb_pkg::CHAN_SHIFT;
    localparam int DROP = hsv2rgb_pkg::SECTOR_SHIFT + 2 * FRACTION_BITS;
    localparam int RECIP_PROD_W = 2 * hsv2rgb_pkg::QUOT_W;

    logic [PROD_W-1:0]               prod_reg;
    logic [SCALED_W-1:0]             prod_ext;
    logic [SCALED_W-1:0]             scaled;
    logic [hsv2rgb_pkg::QUOT_W-1:0]  quot_next;
    logic [hsv2rgb_pkg::QUOT_W-1:0]  quot_reg;
    logic [RECIP_PROD_W-1:0]         recip_prod;
    logic [hsv2rgb_pkg::CHAN_W-1:0]  chan_next;
    logic [hsv2rgb_pkg::CHAN_W-1:0]  chan_reg;

    // Product of brightness and component numerator.
    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_reg <= PROD_W'(bright) * PROD_W'(comp);
        end
    end

    // Times 255, then drop the power-of-two part of the denominator.
    always_comb
    begin
        prod_ext  = SCALED_W'(prod_reg);
        scaled    = (prod_ext << hsv2rgb_pkg::CHAN_SHIFT) - prod_ext;
        quot_next = scaled[DROP +: hsv2rgb_pkg::QUOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en.scale)
        begin
            quot_reg <= quot_next;
        end
    end

    // Divide by the remaining factor 15 through a reciprocal multiply.
    always_comb
    begin
        recip_prod = RECIP_PROD_W'(quot_reg) * RECIP_PROD_W'(hsv2rgb_pkg::RECIP15);
        chan_next  = recip_prod[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        if (en.recip)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ----- hw/rtl/hsv_to_rgb_converter_core.sv -----
// Channel   Direction  Handshake                  Payload
// pixel     in         pixel_valid / pixel_ready  hue, saturation, brightness
// color     out        color_valid / color_ready  red, green, blue
//
// Six register stages: clamp and sector split, saturation products, component
// selection, brightness multiply, scale by 255, reciprocal divide by 15.
// One item per clock unless an output stall has filled every stage.
// Reset clears the stage valid bits only; the data registers are not reset.
// An output stall holds each full stage with no empty stage after it; other
// items move on, so pixel_ready drops only when all six stages hold an item.
module hsv_to_rgb_converter_core #(
    parameter int FRACTION_BITS = hsv2rgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pixel_valid,
    output logic                    pixel_ready,
    input  hsv2rgb_pkg::hsv_pixel_t pixel,
    output logic                    color_valid,
    input  logic                    color_ready,
    output hsv2rgb_pkg::rgb_pixel_t color
);

    localparam int DEPTH = hsv2rgb_pkg::PIPE_DEPTH;
    localparam int VAL_W = (FRACTION_BITS + 1 > hsv2rgb_pkg::INPUT_W) ?
                           FRACTION_BITS + 1 : hsv2rgb_pkg::INPUT_W;
    localparam int ARG_W = FRACTION_BITS + hsv2rgb_pkg::REM_W;
    localparam int MUL_W = VAL_W + hsv2rgb_pkg::REM_W;
    localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRACTION_BITS;
    localparam logic [ARG_W-1:0] A_FULL = ARG_W'(hsv2rgb_pkg::SECTOR_UNITS) << FRACTION_BITS;
    localparam logic [hsv2rgb_pkg::INPUT_W-1:0] BASE1 =
        hsv2rgb_pkg::INPUT_W'(hsv2rgb_pkg::SECTOR_UNITS);
    localparam logic [hsv2rgb_pkg::INPUT_W-1:0] BASE2 =
        hsv2rgb_pkg::INPUT_W'(2 * hsv2rgb_pkg::SECTOR_UNITS);
    localparam logic [hsv2rgb_pkg::INPUT_W-1:0] BASE3 =
        hsv2rgb_pkg::INPUT_W'(3 * hsv2rgb_pkg::SECTOR_UNITS);
    localparam logic [hsv2rgb_pkg::INPUT_W-1:0] BASE4 =
        hsv2rgb_pkg::INPUT_W'(4 * hsv2rgb_pkg::SECTOR_UNITS);
    localparam logic [hsv2rgb_pkg::INPUT_W-1:0] BASE5 =
        hsv2rgb_pkg::INPUT_W'(5 * hsv2rgb_pkg::SECTOR_UNITS);

    logic [DEPTH:1] valid_reg;
    logic [DEPTH:1] valid_next;
    logic [DEPTH:1] stage_en;

    // Stage 1 signals.
    logic [hsv2rgb_pkg::INPUT_W-1:0] hue_clamp;
    logic [hsv2rgb_pkg::INPUT_W-1:0] hue_base;
    hsv2rgb_pkg::sector_t            sector_next;
    logic [VAL_W-1:0]                sat_next;
    logic [VAL_W-1:0]                val_next;
    hsv2rgb_pkg::sector_t            s1_sector_reg;
    logic [hsv2rgb_pkg::REM_W-1:0]   s1_rem_reg;
    logic [VAL_W-1:0]                s1_sat_reg;
    logic [VAL_W-1:0]                s1_val_reg;

    // Stage 2 signals.
    logic [hsv2rgb_pkg::REM_W-1:0]   rem_comp;
    hsv2rgb_pkg::sector_t            s2_sector_reg;
    logic [MUL_W-1:0]                s2_mq_reg;
    logic [MUL_W-1:0]                s2_mt_reg;
    logic [MUL_W-1:0]                s2_mp_reg;
    logic [VAL_W-1:0]                s2_val_reg;

    // Stage 3 signals.
    logic [ARG_W-1:0]                a_p;
    logic [ARG_W-1:0]                a_q;
    logic [ARG_W-1:0]                a_t;
    logic [ARG_W-1:0]                a_red_next;
    logic [ARG_W-1:0]                a_green_next;
    logic [ARG_W-1:0]                a_blue_next;
    logic [ARG_W-1:0]                s3_a_red_reg;
    logic [ARG_W-1:0]                s3_a_green_reg;
    logic [ARG_W-1:0]                s3_a_blue_reg;
    logic [VAL_W-1:0]                s3_val_reg;

    hsv2rgb_pkg::lane_en_t           lane_en;

    // Stage enables: a stage loads when it is empty or the next one loads.
    always_comb
    begin
        stage_en[DEPTH] = !valid_reg[DEPTH] || color_ready;
        for (int k = DEPTH - 1; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k + 1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[1])
        begin
            valid_next[1] = pixel_valid;
        end
        for (int k = 2; k <= DEPTH; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = valid_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pixel_ready = stage_en[1];
    assign color_valid = valid_reg[DEPTH];

    // Stage 1: clamp the fields and split hue into sector and remainder.
    always_comb
    begin
        hue_clamp = (pixel.hue > hsv2rgb_pkg::HUE_MAX) ? hsv2rgb_pkg::HUE_MAX : pixel.hue;
        sat_next  = (VAL_W'(pixel.saturation) > ONE) ? ONE : VAL_W'(pixel.saturation);
        val_next  = (VAL_W'(pixel.brightness) > ONE) ? ONE : VAL_W'(pixel.brightness);
        priority if (hue_clamp >= BASE5)
        begin
            sector_next = hsv2rgb_pkg::SEC_MAGENTA_RED;
            hue_base    = BASE5;
        end
        else if (hue_clamp >= BASE4)
        begin
            sector_next = hsv2rgb_pkg::SEC_BLUE_MAGENTA;
            hue_base    = BASE4;
        end
        else if (hue_clamp >= BASE3)
        begin
            sector_next = hsv2rgb_pkg::SEC_CYAN_BLUE;
            hue_base    = BASE3;
        end
        else if (hue_clamp >= BASE2)
        begin
            sector_next = hsv2rgb_pkg::SEC_GREEN_CYAN;
            hue_base    = BASE2;
        end
        else if (hue_clamp >= BASE1)
        begin
            sector_next = hsv2rgb_pkg::SEC_YELLOW_GREEN;
            hue_base    = BASE1;
        end
        else
        begin
            sector_next = hsv2rgb_pkg::SEC_RED_YELLOW;
            hue_base    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s1_sector_reg <= sector_next;
            s1_rem_reg    <= hsv2rgb_pkg::REM_W'(hue_clamp - hue_base);
            s1_sat_reg    <= sat_next;
            s1_val_reg    <= val_next;
        end
    end

    // Stage 2: saturation times the sector fraction, its complement and 960.
    assign rem_comp = hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::SECTOR_UNITS) - s1_rem_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_mq_reg     <= MUL_W'(s1_sat_reg) * MUL_W'(s1_rem_reg);
            s2_mt_reg     <= MUL_W'(s1_sat_reg) * MUL_W'(rem_comp);
            s2_mp_reg     <= MUL_W'(s1_sat_reg) * MUL_W'(hsv2rgb_pkg::SECTOR_UNITS);
            s2_val_reg    <= s1_val_reg;
        end
    end

    // Stage 3: form the p, q and t numerators and route them by sector.
    always_comb
    begin
        a_p = A_FULL - ARG_W'(s2_mp_reg);
        a_q = A_FULL - ARG_W'(s2_mq_reg);
        a_t = A_FULL - ARG_W'(s2_mt_reg);
        unique case (s2_sector_reg)
            hsv2rgb_pkg::SEC_RED_YELLOW:
            begin
                a_red_next = A_FULL; a_green_next = a_t; a_blue_next = a_p;
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN:
            begin
                a_red_next = a_q; a_green_next = A_FULL; a_blue_next = a_p;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN:
            begin
                a_red_next = a_p; a_green_next = A_FULL; a_blue_next = a_t;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE:
            begin
                a_red_next = a_p; a_green_next = a_q; a_blue_next = A_FULL;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA:
            begin
                a_red_next = a_t; a_green_next = a_p; a_blue_next = A_FULL;
            end
            default:
            begin
                a_red_next = A_FULL; a_green_next = a_p; a_blue_next = a_q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s3_a_red_reg   <= a_red_next;
            s3_a_green_reg <= a_green_next;
            s3_a_blue_reg  <= a_blue_next;
            s3_val_reg     <= s2_val_reg;
        end
    end

    // Stages 4 to 6 live in the channel lanes.
    assign lane_en.mul   = stage_en[4];
    assign lane_en.scale = stage_en[5];
    assign lane_en.recip = stage_en[6];

    hsv2rgb_lane #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_lane_red (
        .clk    (clk),
        .en     (lane_en),
        .bright (s3_val_reg),
        .comp   (s3_a_red_reg),
        .chan   (color.red)
    );

    hsv2rgb_lane #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_lane_green (
        .clk    (clk),
        .en     (lane_en),
        .bright (s3_val_reg),
        .comp   (s3_a_green_reg),
        .chan   (color.green)
    );

    hsv2rgb_lane #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_lane_blue (
        .clk    (clk),
        .en     (lane_en),
        .bright (s3_val_reg),
        .comp   (s3_a_blue_reg),
        .chan   (color.blue)
    );

    // A full pipeline under an output stall must refuse new items.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !color_ready |-> !pixel_ready)
        else $error("pipeline accepted an item while full and stalled");

    // Clamped fields never exceed 1.0 and the remainder stays inside a sector.
    a_stage1_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> (s1_sat_reg <= ONE) && (s1_val_reg <= ONE) &&
                         (s1_rem_reg < hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::SECTOR_UNITS)))
        else $error("stage 1 field out of range");

    // Every sector gives the full brightness to at least one channel.
    a_value_routed: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> (s3_a_red_reg == A_FULL) || (s3_a_green_reg == A_FULL) ||
                         (s3_a_blue_reg == A_FULL))
        else $error("no channel carries the value component");

    // An item held in stage 3 keeps its valid bit while the output stalls.
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] && !stage_en[3] |=> valid_reg[3])
        else $error("stalled stage lost its item");

endmodule

// ----- tb/tb_hsv_to_rgb_converter_core.sv -----
module tb_hsv_to_rgb_converter_core;

    localparam int FRAC_BITS    = hsv2rgb_pkg::FRACTION_BITS_DEF;
    localparam int RANDOM_ITEMS = 1250;

    logic                    clk;
    logic                    rst_n;
    logic                    pixel_valid;
    logic                    pixel_ready;
    hsv2rgb_pkg::hsv_pixel_t pixel;
    logic                    color_valid;
    logic                    color_ready;
    hsv2rgb_pkg::rgb_pixel_t color;

    // Set during a stretch of the run in which neither side inserts gaps.
    bit no_idle;

    // Keeps the colors still owed by the block, oldest first, and checks each
    // returned item against them.
    class color_scoreboard;
        hsv2rgb_pkg::rgb_pixel_t expected_colors[$];
        int                      errors;

        function new();
            errors = 0;
        endfunction

        // Truncated product of a component with 255, capped at 255; the component is num / den.
        function longint unsigned scale_channel(longint unsigned num,
                                                longint unsigned den);
            longint unsigned c;
            c = (num * 255) / den;
            return (c > 255) ? 255 : c;
        endfunction

        // Six-sector conversion, exact up to the final truncation.
        function hsv2rgb_pkg::rgb_pixel_t hsv_to_rgb(hsv2rgb_pkg::hsv_pixel_t px);
            longint unsigned         one, h, s, v, rem, den;
            longint unsigned         cv, cp, cq, ct;
            hsv2rgb_pkg::sector_t    sec;
            hsv2rgb_pkg::rgb_pixel_t c;
            one = 64'd1 << FRAC_BITS;
            h = px.hue;
            s = px.saturation;
            v = px.brightness;
            if (h > hsv2rgb_pkg::HUE_MAX) h = hsv2rgb_pkg::HUE_MAX;
            if (s > one) s = one;
            if (v > one) v = one;
            c = '0;
            if (v != 0)
            begin
                sec = hsv2rgb_pkg::sector_t'(h / hsv2rgb_pkg::SECTOR_UNITS);
                rem = h % hsv2rgb_pkg::SECTOR_UNITS;
                den = hsv2rgb_pkg::SECTOR_UNITS * one * one;
                cv = scale_channel(v * hsv2rgb_pkg::SECTOR_UNITS * one, den);
                cp = scale_channel(v * hsv2rgb_pkg::SECTOR_UNITS * (one - s), den);
                cq = scale_channel(v * (hsv2rgb_pkg::SECTOR_UNITS * one - s * rem), den);
                ct = scale_channel(v * (hsv2rgb_pkg::SECTOR_UNITS * one -
                                        s * (hsv2rgb_pkg::SECTOR_UNITS - rem)), den);
                case (sec)
                    hsv2rgb_pkg::SEC_RED_YELLOW:   c = '{cv[7:0], ct[7:0], cp[7:0]};
                    hsv2rgb_pkg::SEC_YELLOW_GREEN: c = '{cq[7:0], cv[7:0], cp[7:0]};
                    hsv2rgb_pkg::SEC_GREEN_CYAN:   c = '{cp[7:0], cv[7:0], ct[7:0]};
                    hsv2rgb_pkg::SEC_CYAN_BLUE:    c = '{cp[7:0], cq[7:0], cv[7:0]};
                    hsv2rgb_pkg::SEC_BLUE_MAGENTA: c = '{ct[7:0], cp[7:0], cv[7:0]};
                    default:                       c = '{cv[7:0], cp[7:0], cq[7:0]};
                endcase
            end
            return c;
        endfunction

        function void note_pixel(hsv2rgb_pkg::hsv_pixel_t px);
            expected_colors.push_back(hsv_to_rgb(px));
        endfunction

        function void check_channel(string name,
                                    logic [hsv2rgb_pkg::CHAN_W-1:0] exp_val,
                                    logic [hsv2rgb_pkg::CHAN_W-1:0] act_val);
            if (act_val !== exp_val)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, exp_val,
                         act_val);
                errors++;
            end
        endfunction

        function void check_color(hsv2rgb_pkg::rgb_pixel_t got);
            hsv2rgb_pkg::rgb_pixel_t want;
            if (expected_colors.size() == 0)
            begin
                $display("%0t: unexpected color item, expected none actual %h",
                         $time, got);
                errors++;
            end
            else
            begin
                want = expected_colors.pop_front();
                check_channel("red", want.red, got.red);
                check_channel("green", want.green, got.green);
                check_channel("blue", want.blue, got.blue);
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    color_scoreboard sb;

    hsv_to_rgb_converter_core #(
        .FRACTION_BITS(FRAC_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .pixel      (pixel),
        .color_valid(color_valid),
        .color_ready(color_ready),
        .color      (color)
    );

    // Clock with a period of 12.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Mostly legal pixels that lean toward sector edges and the ends of the
    // fixed-point range; the rest is raw 13-bit noise that exercises clamping.
    function automatic hsv2rgb_pkg::hsv_pixel_t random_pixel();
        hsv2rgb_pkg::hsv_pixel_t px;
        int                      h;
        if ($urandom_range(0, 99) < 15)
        begin
            px.hue        = hsv2rgb_pkg::INPUT_W'($urandom_range(0, 8191));
            px.saturation = hsv2rgb_pkg::INPUT_W'($urandom_range(0, 8191));
            px.brightness = hsv2rgb_pkg::INPUT_W'($urandom_range(0, 8191));
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                h = $urandom_range(0, 5) * hsv2rgb_pkg::SECTOR_UNITS;
                case ($urandom_range(0, 3))
                    0: h = h;
                    1: h = h + 1;
                    2: h = h + hsv2rgb_pkg::SECTOR_UNITS - 2;
                    default: h = h + hsv2rgb_pkg::SECTOR_UNITS - 1;
                endcase
                if (h > hsv2rgb_pkg::HUE_MAX) h = hsv2rgb_pkg::HUE_MAX;
                px.hue = hsv2rgb_pkg::INPUT_W'(h);
            end
            else
            begin
                px.hue = hsv2rgb_pkg::INPUT_W'($urandom_range(0, hsv2rgb_pkg::HUE_MAX));
            end
            if ($urandom_range(0, 9) == 0)
                px.saturation = hsv2rgb_pkg::INPUT_W'($urandom_range(0, 1) ? 4096 : 0);
            else
                px.saturation = hsv2rgb_pkg::INPUT_W'($urandom_range(0, 4096));
            case ($urandom_range(0, 19))
                0: px.brightness = hsv2rgb_pkg::INPUT_W'(0);
                1: px.brightness = hsv2rgb_pkg::INPUT_W'(1);
                2: px.brightness = hsv2rgb_pkg::INPUT_W'(4096);
                default: px.brightness = hsv2rgb_pkg::INPUT_W'($urandom_range(0, 4096));
            endcase
        end
        return px;
    endfunction

    // Offers one pixel after a random gap and returns once it is accepted.
    task automatic send_pixel(hsv2rgb_pkg::hsv_pixel_t px);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        do @(posedge clk); while (!pixel_ready);
    endtask

    task automatic send_hsv(int h, int s, int v);
        hsv2rgb_pkg::hsv_pixel_t px;
        px.hue        = hsv2rgb_pkg::INPUT_W'(h);
        px.saturation = hsv2rgb_pkg::INPUT_W'(s);
        px.brightness = hsv2rgb_pkg::INPUT_W'(v);
        send_pixel(px);
    endtask

    // Stops offering pixels until every owed color has come back.
    task automatic wait_for_colors();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Record accepted pixels and check returned colors.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
                sb.note_pixel(pixel);
            if (color_valid && color_ready)
                sb.check_color(color);
        end
    end

    // Output side: random stalls of varied length between bursts of ready.
    initial
    begin
        int stall;
        color_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_cycles();
            if (stall > 0)
            begin
                color_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            color_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Reset, directed pixels, random pixels, then drain and report.
    initial
    begin
        sb          = new();
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel       = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Black, sector edges at full saturation, hue clamping.
        send_hsv(0, 0, 0);
        send_hsv(0, 4096, 4096);
        send_hsv(959, 4096, 4096);
        send_hsv(960, 4096, 4096);
        send_hsv(1919, 4096, 4096);
        send_hsv(1920, 4096, 4096);
        send_hsv(2880, 4096, 4096);
        send_hsv(3840, 4096, 4096);
        send_hsv(4800, 4096, 4096);
        send_hsv(5743, 4096, 4096);
        send_hsv(5744, 4096, 4096);
        send_hsv(5745, 4096, 4096);
        // All-ones fields, saturation and brightness above one, grey levels.
        send_hsv(8191, 8191, 8191);
        send_hsv(480, 0, 4096);
        send_hsv(2400, 8191, 4096);
        send_hsv(4000, 2048, 1);
        send_hsv(3000, 4096, 0);
        send_hsv(8191, 0, 8191);
        send_hsv(1234, 4097, 4097);
        send_hsv(100, 1, 1);
        send_hsv(4321, 2731, 3000);
        send_hsv(5000, 4096, 2048);
        wait_for_colors();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= 500 && n < 700);
            if (n == 900)
                wait_for_colors();
            send_pixel(random_pixel());
        end

        wait_for_colors();
        repeat (3 * hsv2rgb_pkg::PIPE_DEPTH) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #(12 * 1000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
